[rtl/core/char_lcd_write_formatter_top_macros.svh]
// Assertion macros for the LCD write formatter.
// Used by the top level only; expects clk and rst in scope.
`ifndef CHAR_LCD_WRITE_FORMATTER_TOP_MACROS_SVH
`define CHAR_LCD_WRITE_FORMATTER_TOP_MACROS_SVH

// same-cycle implication
`define CLWF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CLWF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/clwf_pkg.sv]
// Shared types, constants and helpers for the LCD write formatter.
// No dependencies; imported by every module of the block.
package clwf_pkg;

  localparam int MAX_DIGITS = 5;
  localparam int VALUE_W    = 16;
  localparam int BIT_CNT_W  = $clog2(VALUE_W);
  localparam int DIG_IDX_W  = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int CNT_W      = 4;

  localparam logic [7:0] LCD_SET_ADDR   = 8'h80;
  localparam logic [7:0] LCD_ROW2_OFS   = 8'h40;
  localparam logic [7:0] LCD_FUNC_SET   = 8'h38;
  localparam logic [7:0] LCD_DISP_ON    = 8'h0C;
  localparam logic [7:0] LCD_ENTRY_MODE = 8'h06;
  localparam logic [7:0] LCD_CLEAR      = 8'h01;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_X     = 8'h58;

  typedef enum logic [2:0] {
    REQ_INIT = 3'd0,
    REQ_CHAR = 3'd1,
    REQ_UDEC = 3'd2,
    REQ_SDEC = 3'd3,
    REQ_BIN  = 3'd4,
    REQ_HEX  = 3'd5
  } req_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POS,
    ST_PRE,
    ST_BODY
  } emit_state_t;

  typedef logic [MAX_DIGITS-1:0][3:0] bcd_t;

  typedef struct packed {
    req_kind_t        kind;
    logic             pos_en;
    logic [7:0]       pos_byte;
    logic             neg;
    logic [1:0]       pre_cnt;
    logic [CNT_W-1:0] body_cnt;
    logic [7:0]       data;
  } emit_load_t;

  typedef struct packed {
    logic             busy;
    logic [CNT_W-1:0] rem;
  } emit_stat_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] wide;
    wide = {4'd0, nib};
    if (nib >= 4'd10) hex_char = wide - 8'd10 + CH_A;
    else              hex_char = wide + CH_ZERO;
  endfunction

  // body count runs 4..1 over the setup commands
  function automatic logic [7:0] init_cmd(input logic [2:0] n);
    case (n)
      3'd4:    init_cmd = LCD_FUNC_SET;
      3'd3:    init_cmd = LCD_DISP_ON;
      3'd2:    init_cmd = LCD_ENTRY_MODE;
      default: init_cmd = LCD_CLEAR;
    endcase
  endfunction

endpackage

[rtl/core/clwf_bcd.sv]
// Bit-serial binary to BCD converter (shift-and-add-3), one bit per cycle.
// Depends on clwf_pkg.
module clwf_bcd (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic [clwf_pkg::VALUE_W-1:0]          bin,
  output logic                                  busy,
  output clwf_pkg::bcd_t                        digits
);
  import clwf_pkg::*;

  logic [VALUE_W-1:0]      sr;
  logic [BIT_CNT_W-1:0]    cnt;
  bcd_t                    adj;
  logic [4*MAX_DIGITS:0]   shifted;

  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      adj[i] = (digits[i] >= 4'd5) ? digits[i] + 4'd3 : digits[i];
    end
    shifted = {adj, sr[VALUE_W-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= BIT_CNT_W'(VALUE_W - 1);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == '0) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sr     <= bin;
      digits <= '0;
    end else if (busy) begin
      sr     <= {sr[VALUE_W-2:0], 1'b0};
      digits <= shifted[4*MAX_DIGITS-1:0];
    end
  end

endmodule

[rtl/core/clwf_emit.sv]
// Byte sequencer: position command, prefix bytes, then body bytes taken from
// a small shift register, the BCD digits or the init commands, into a registered output stage.
// Depends on clwf_pkg.
module clwf_emit (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  clwf_pkg::emit_load_t   ld,
  input  clwf_pkg::bcd_t         digits,
  input  logic                   bcd_busy,
  output clwf_pkg::emit_stat_t   stat,
  output logic                   lcd_valid,
  input  logic                   lcd_stall,
  output logic [7:0]             bus_byte,
  output logic                   is_data,
  output logic                   last
);
  import clwf_pkg::*;

  emit_state_t          state, state_next;
  req_kind_t            kind;
  logic [7:0]           pos_byte;
  logic                 neg;
  logic [1:0]           pre_cnt;
  logic [CNT_W-1:0]     body_cnt;
  logic [7:0]           sh;
  logic [CNT_W-1:0]     rem;

  logic                 out_free;
  logic                 dec_kind;
  logic                 can_emit;
  logic [DIG_IDX_W-1:0] dig_idx;
  logic [7:0]           byte_val;
  logic                 data_flag;

  assign out_free = !lcd_valid || !lcd_stall;
  assign dec_kind = (kind == REQ_UDEC) || (kind == REQ_SDEC);
  // decimal digits wait for the converter
  assign can_emit = out_free && (state != ST_IDLE) &&
                    !(state == ST_BODY && dec_kind && bcd_busy);
  assign dig_idx  = DIG_IDX_W'(body_cnt - 1'b1);

  assign stat.busy = (state != ST_IDLE);
  assign stat.rem  = rem;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (load) begin
          if (ld.pos_en)                state_next = ST_POS;
          else if (ld.pre_cnt != 2'd0)  state_next = ST_PRE;
          else if (ld.body_cnt != '0)   state_next = ST_BODY;
        end
      end
      ST_POS: begin
        if (can_emit) begin
          if (pre_cnt != 2'd0)       state_next = ST_PRE;
          else if (body_cnt != '0)   state_next = ST_BODY;
          else                       state_next = ST_IDLE;
        end
      end
      ST_PRE: begin
        if (can_emit && pre_cnt == 2'd1) begin
          state_next = (body_cnt != '0) ? ST_BODY : ST_IDLE;
        end
      end
      ST_BODY: begin
        if (can_emit && body_cnt == CNT_W'(1)) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // byte for the current step
  always_comb begin
    byte_val  = 8'h00;
    data_flag = 1'b1;
    case (state)
      ST_POS: begin
        byte_val  = pos_byte;
        data_flag = 1'b0;
      end
      ST_PRE: begin
        if (kind == REQ_HEX) byte_val = (pre_cnt == 2'd2) ? CH_ZERO : CH_X;
        else                 byte_val = neg ? CH_MINUS : CH_PLUS;
      end
      ST_BODY: begin
        case (kind)
          REQ_INIT: begin
            byte_val  = init_cmd(body_cnt[2:0]);
            data_flag = 1'b0;
          end
          REQ_CHAR: byte_val = sh;
          REQ_UDEC,
          REQ_SDEC: byte_val = CH_ZERO + {4'd0, digits[dig_idx]};
          REQ_BIN:  byte_val = CH_ZERO + {7'd0, sh[7]};
          REQ_HEX:  byte_val = hex_char(sh[7:4]);
          default:  byte_val = 8'h00;
        endcase
      end
      default: byte_val = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      rem   <= '0;
    end else begin
      state <= state_next;
      if (load)          rem <= CNT_W'(ld.pos_en) + CNT_W'(ld.pre_cnt) + ld.body_cnt;
      else if (can_emit) rem <= rem - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind     <= ld.kind;
      pos_byte <= ld.pos_byte;
      neg      <= ld.neg;
      pre_cnt  <= ld.pre_cnt;
      body_cnt <= ld.body_cnt;
      sh       <= ld.data;
    end else if (can_emit) begin
      if (state == ST_PRE) pre_cnt <= pre_cnt - 1'b1;
      if (state == ST_BODY) begin
        body_cnt <= body_cnt - 1'b1;
        if (kind == REQ_BIN)      sh <= {sh[6:0], 1'b0};
        else if (kind == REQ_HEX) sh <= {sh[3:0], 4'd0};
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      lcd_valid <= 1'b0;
    end else if (can_emit) begin
      lcd_valid <= 1'b1;
    end else if (!lcd_stall) begin
      lcd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (can_emit) begin
      bus_byte <= byte_val;
      is_data  <= data_flag;
      last     <= (rem == CNT_W'(1));
    end
  end

endmodule

[rtl/core/char_lcd_write_formatter_top.sv]
// Channel  | handshake            | payload
// req      | req_valid/req_stall  | req_type, row, col, value, length
// lcd      | lcd_valid/lcd_stall  | bus_byte, is_data, last
//
// One request at a time; output bytes go out one per cycle while lcd is not stalled.
// Decimal modes run a bit-serial BCD conversion that overlaps the position and
// sign bytes; the digit bytes wait for it to finish.
// rst (synchronous) empties the output register and returns to idle.
// A stall on lcd holds the output byte and pauses the sequencer.
// Depends on clwf_pkg, clwf_bcd, clwf_emit and the macros header.
`include "char_lcd_write_formatter_top_macros.svh"

module char_lcd_write_formatter_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [2:0]  req_type,
  input  logic [1:0]  row,
  input  logic [5:0]  col,
  input  logic [15:0] value,
  input  logic [2:0]  length,
  output logic        lcd_valid,
  input  logic        lcd_stall,
  output logic [7:0]  bus_byte,
  output logic        is_data,
  output logic        last
);
  import clwf_pkg::*;

  logic               req_accept;
  logic               kind_ok;
  req_kind_t          kind;
  logic               row_pos;
  logic [7:0]         addr;
  logic [VALUE_W-1:0] mag;
  logic [CNT_W-1:0]   len_sat;
  emit_load_t         ld;
  emit_stat_t         stat;
  logic               bcd_start;
  logic               bcd_busy;
  bcd_t               digits;

  assign req_accept = req_valid && !req_stall;
  assign req_stall  = stat.busy || bcd_busy;

  assign kind_ok = (req_type <= REQ_HEX);
  assign kind    = req_kind_t'(req_type);
  assign row_pos = (row == 2'd1) || (row == 2'd2);
  // col - 1 wraps inside the byte; row 2 adds the second-line offset
  assign addr    = {2'b00, col} + 8'hFF + ((row == 2'd2) ? LCD_ROW2_OFS : 8'h00);
  assign mag     = (kind == REQ_SDEC && value[VALUE_W-1]) ? (~value + 1'b1) : value;
  assign len_sat = (32'(length) > MAX_DIGITS) ? CNT_W'(MAX_DIGITS) : CNT_W'(length);

  assign bcd_start = req_accept && kind_ok && (kind == REQ_UDEC || kind == REQ_SDEC);

  always_comb begin
    ld          = '0;
    ld.kind     = kind;
    ld.pos_byte = LCD_SET_ADDR | addr;
    ld.neg      = value[VALUE_W-1];
    ld.data     = value[7:0];
    if (kind_ok) begin
      ld.pos_en = row_pos && (kind != REQ_INIT);
      case (kind)
        REQ_INIT: ld.body_cnt = CNT_W'(4);
        REQ_CHAR: ld.body_cnt = CNT_W'(1);
        REQ_UDEC: ld.body_cnt = len_sat;
        REQ_SDEC: begin
          ld.pre_cnt  = 2'd1;
          ld.body_cnt = len_sat;
        end
        REQ_BIN:  ld.body_cnt = CNT_W'(8);
        REQ_HEX: begin
          ld.pre_cnt  = 2'd2;
          ld.body_cnt = CNT_W'(2);
        end
        default:  ld.body_cnt = '0;
      endcase
    end
  end

  clwf_bcd u_bcd (
    .clk    (clk),
    .rst    (rst),
    .start  (bcd_start),
    .bin    (mag),
    .busy   (bcd_busy),
    .digits (digits)
  );

  clwf_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .load      (req_accept),
    .ld        (ld),
    .digits    (digits),
    .bcd_busy  (bcd_busy),
    .stat      (stat),
    .lcd_valid (lcd_valid),
    .lcd_stall (lcd_stall),
    .bus_byte  (bus_byte),
    .is_data   (is_data),
    .last      (last)
  );

  `CLWF_ASSERT_IMPL(a_rem_live, stat.busy, stat.rem != '0, "sequencer busy with no bytes left")
  `CLWF_ASSERT_NEXT(a_bcd_runs, bcd_start, bcd_busy, "converter did not start on decimal request")
  `CLWF_ASSERT_IMPL(a_last_on_exit, $fell(stat.busy), lcd_valid && last, "request ended without last")

endmodule

[tb/sv/char_lcd_write_formatter_top_tb.sv]
// Self-checking testbench for char_lcd_write_formatter_top: a directed table, then random requests.
// LCD bytes are predicted by a behavioral formatter and checked in order as they leave the block.
// Depends on clwf_pkg and the RTL of the block.
module char_lcd_write_formatter_top_tb;
  import clwf_pkg::*;

  localparam int RST_CYCLES  = 11;
  localparam int RAND_REQS   = 285;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 64;
  localparam int MAX_SHOWN   = 10;
  localparam int DIR_ROWS    = 25;

  // request types the block must ignore
  localparam logic [2:0] REQ_BAD6 = 3'd6;
  localparam logic [2:0] REQ_BAD7 = 3'd7;

  typedef struct packed {
    logic [7:0] bus_byte;
    logic       is_data;
    logic       last;
  } lcd_word_t;

  // fixed rows carry their bytes inline, the rest go through the formatter
  typedef struct packed {
    logic [2:0]       kind;
    logic [1:0]       row;
    logic [5:0]       col;
    logic [15:0]      value;
    logic [2:0]       len;
    logic             fixed;
    logic [3:0]       n_fix;
    logic [0:8][7:0]  fix_byte;
    logic [0:8]       fix_data;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic [2:0]  req_type = '0;
  logic [1:0]  row = '0;
  logic [5:0]  col = '0;
  logic [15:0] value = '0;
  logic [2:0]  length = '0;
  logic        lcd_stall = 1'b0;
  logic        req_stall;
  logic        lcd_valid;
  logic [7:0]  bus_byte;
  logic        is_data;
  logic        last;

  logic        quiet = 1'b0;
  int unsigned cycle_cnt = 0;
  int          fail_cnt = 0;
  int          bytes_seen = 0;
  int          kind_seen [8];
  lcd_word_t   lcd_expect_q [$];
  dir_row_t    dir_tab [DIR_ROWS];

  char_lcd_write_formatter_top dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_type  (req_type),
    .row       (row),
    .col       (col),
    .value     (value),
    .length    (length),
    .lcd_valid (lcd_valid),
    .lcd_stall (lcd_stall),
    .bus_byte  (bus_byte),
    .is_data   (is_data),
    .last      (last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes still expected", cycle_cnt,
               lcd_expect_q.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    lcd_stall <= !quiet && ($urandom_range(99) < 6);
  end

  function automatic logic [7:0] nib_to_ascii(input logic [3:0] nib);
    if (nib >= 4'd10) return CH_A + {4'd0, nib} - 8'd10;
    return CH_ZERO + {4'd0, nib};
  endfunction

  function automatic void push_byte(input logic [7:0] b, input logic d);
    lcd_word_t w;
    w.bus_byte = b;
    w.is_data  = d;
    w.last     = 1'b0;
    lcd_expect_q.push_back(w);
  endfunction

  // zero padded, most significant first; digits above the count are dropped
  function automatic void push_decimal(input logic [15:0] mag, input int digits);
    int scale;
    int dig;
    for (int k = digits; k > 0; k--) begin
      scale = 1;
      for (int j = 1; j < k; j++) scale = scale * 10;
      dig = (int'(mag) / scale) % 10;
      push_byte(CH_ZERO + dig[7:0], 1'b1);
    end
  endfunction

  function automatic void format_request(input logic [2:0] kind, input logic [1:0] rw,
                                         input logic [5:0] cl, input logic [15:0] val,
                                         input logic [2:0] len);
    int          start;
    int          digits;
    logic [7:0]  addr;
    logic [15:0] neg_mag;
    lcd_word_t   tail_word;
    start  = lcd_expect_q.size();
    digits = (len > MAX_DIGITS) ? MAX_DIGITS : int'(len);
    if (kind == REQ_INIT) begin
      push_byte(LCD_FUNC_SET, 1'b0);
      push_byte(LCD_DISP_ON, 1'b0);
      push_byte(LCD_ENTRY_MODE, 1'b0);
      push_byte(LCD_CLEAR, 1'b0);
    end else if (kind <= REQ_HEX) begin
      if (rw == 2'd1 || rw == 2'd2) begin
        // col - 1 wraps inside the byte, so column zero gives 0xFF / 0xBF on the bus
        addr = {2'b00, cl} + 8'hFF + ((rw == 2'd2) ? LCD_ROW2_OFS : 8'h00);
        push_byte(LCD_SET_ADDR | addr, 1'b0);
      end
      case (kind)
        REQ_CHAR: push_byte(val[7:0], 1'b1);
        REQ_UDEC: push_decimal(val, digits);
        REQ_SDEC: begin
          if (!val[15]) begin
            push_byte(CH_PLUS, 1'b1);
            push_decimal(val, digits);
          end else begin
            neg_mag = -val;
            push_byte(CH_MINUS, 1'b1);
            push_decimal(neg_mag, digits);
          end
        end
        REQ_BIN: begin
          for (int i = 7; i >= 0; i--) push_byte(CH_ZERO + {7'd0, val[i]}, 1'b1);
        end
        default: begin
          push_byte(CH_ZERO, 1'b1);
          push_byte(CH_X, 1'b1);
          push_byte(nib_to_ascii(val[7:4]), 1'b1);
          push_byte(nib_to_ascii(val[3:0]), 1'b1);
        end
      endcase
    end
    if (lcd_expect_q.size() > start) begin
      tail_word      = lcd_expect_q.pop_back();
      tail_word.last = 1'b1;
      lcd_expect_q.push_back(tail_word);
    end
  endfunction

  // returns in the step at which the request was taken
  task automatic send_request(input logic [2:0] kind, input logic [1:0] rw, input logic [5:0] cl,
                              input logic [15:0] val, input logic [2:0] len);
    while (!quiet && $urandom_range(99) < 6) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_type  <= kind;
    row       <= rw;
    col       <= cl;
    value     <= val;
    length    <= len;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    kind_seen[kind]++;
  endtask

  task automatic drain_requests();
    req_valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (lcd_expect_q.size() != 0);
  endtask

  always @(posedge clk) begin
    lcd_word_t got;
    lcd_word_t want;
    if (!rst && lcd_valid && !lcd_stall) begin
      got.bus_byte = bus_byte;
      got.is_data  = is_data;
      got.last     = last;
      bytes_seen++;
      if (lcd_expect_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= MAX_SHOWN)
          $display("unexpected lcd byte %02h is_data=%0b last=%0b at cycle %0d",
                   got.bus_byte, got.is_data, got.last, cycle_cnt);
      end else begin
        want = lcd_expect_q.pop_front();
        if (got.bus_byte !== want.bus_byte || got.is_data !== want.is_data ||
            got.last !== want.last) begin
          fail_cnt++;
          if (fail_cnt <= MAX_SHOWN)
            $display("lcd byte mismatch at cycle %0d: exp %02h/%0b/%0b got %02h/%0b/%0b",
                     cycle_cnt, want.bus_byte, want.is_data, want.last,
                     got.bus_byte, got.is_data, got.last);
        end
      end
    end
  end

  initial begin
    dir_row_t    r;
    int          sent_ok;
    int          idx;
    int          pick;
    logic [2:0]  k;
    logic [1:0]  rw;
    logic [5:0]  cl;
    logic [15:0] val;
    logic [2:0]  len;
    lcd_word_t   w;

    for (int i = 0; i < 8; i++) kind_seen[i] = 0;

    // init ignores every other field
    dir_tab[0]  = '{REQ_INIT, 2'd0, 6'd0, 16'h0000, 3'd0, 1'b1, 4'd4,
                    {8'h38, 8'h0C, 8'h06, 8'h01, 40'h0}, 9'b000000000};
    dir_tab[1]  = '{REQ_INIT, 2'd2, 6'd63, 16'hFFFF, 3'd7, 1'b1, 4'd4,
                    {8'h38, 8'h0C, 8'h06, 8'h01, 40'h0}, 9'b000000000};
    dir_tab[2]  = '{REQ_CHAR, 2'd1, 6'd1, 16'h0041, 3'd0, 1'b1, 4'd2,
                    {8'h80, 8'h41, 56'h0}, 9'b010000000};
    dir_tab[3]  = '{REQ_CHAR, 2'd2, 6'd40, 16'hFF7E, 3'd0, 1'b1, 4'd2,
                    {8'hE7, 8'h7E, 56'h0}, 9'b010000000};
    // column zero wraps
    dir_tab[4]  = '{REQ_CHAR, 2'd1, 6'd0, 16'h0000, 3'd0, 1'b1, 4'd2,
                    {8'hFF, 8'h00, 56'h0}, 9'b010000000};
    dir_tab[5]  = '{REQ_CHAR, 2'd2, 6'd0, 16'hFFFF, 3'd0, 1'b1, 4'd2,
                    {8'hBF, 8'hFF, 56'h0}, 9'b010000000};
    dir_tab[6]  = '{REQ_CHAR, 2'd0, 6'd5, 16'h1234, 3'd0, 1'b1, 4'd1,
                    {8'h34, 64'h0}, 9'b100000000};
    dir_tab[7]  = '{REQ_CHAR, 2'd3, 6'd63, 16'h00AA, 3'd0, 1'b1, 4'd1,
                    {8'hAA, 64'h0}, 9'b100000000};
    dir_tab[8]  = '{REQ_UDEC, 2'd1, 6'd63, 16'hFFFF, 3'd5, 1'b0, 4'd0, 72'h0, 9'h0};
    dir_tab[9]  = '{REQ_UDEC, 2'd2, 6'd1, 16'h0000, 3'd5, 1'b0, 4'd0, 72'h0, 9'h0};
    // leading digits dropped, then length saturation
    dir_tab[10] = '{REQ_UDEC, 2'd1, 6'd3, 16'd12345, 3'd3, 1'b0, 4'd0, 72'h0, 9'h0};
    dir_tab[11] = '{REQ_UDEC, 2'd1, 6'd2, 16'd7, 3'd7, 1'b0, 4'd0, 72'h0, 9'h0};
    // zero length: nothing at all, or just the position command
    dir_tab[12] = '{REQ_UDEC, 2'd0, 6'd1, 16'd99, 3'd0, 1'b1, 4'd0, 72'h0, 9'h0};
    dir_tab[13] = '{REQ_UDEC, 2'd2, 6'd10, 16'd500, 3'd0, 1'b1, 4'd1,
                    {8'hC9, 64'h0}, 9'b000000000};
    dir_tab[14] = '{REQ_SDEC, 2'd1, 6'd1, 16'h7FFF, 3'd5, 1'b0, 4'd0, 72'h0, 9'h0};
    // most negative shows as 32768
    dir_tab[15] = '{REQ_SDEC, 2'd2, 6'd5, 16'h8000, 3'd5, 1'b0, 4'd0, 72'h0, 9'h0};
    dir_tab[16] = '{REQ_SDEC, 2'd1, 6'd1, 16'hFFFF, 3'd6, 1'b0, 4'd0, 72'h0, 9'h0};
    dir_tab[17] = '{REQ_SDEC, 2'd0, 6'd1, 16'h0000, 3'd0, 1'b1, 4'd1,
                    {8'h2B, 64'h0}, 9'b100000000};
    dir_tab[18] = '{REQ_SDEC, 2'd3, 6'd1, 16'h8001, 3'd0, 1'b1, 4'd1,
                    {8'h2D, 64'h0}, 9'b100000000};
    dir_tab[19] = '{REQ_BIN, 2'd1, 6'd1, 16'hFFA5, 3'd0, 1'b0, 4'd0, 72'h0, 9'h0};
    dir_tab[20] = '{REQ_BIN, 2'd0, 6'd20, 16'hFF00, 3'd7, 1'b0, 4'd0, 72'h0, 9'h0};
    dir_tab[21] = '{REQ_HEX, 2'd2, 6'd40, 16'h12AF, 3'd0, 1'b0, 4'd0, 72'h0, 9'h0};
    dir_tab[22] = '{REQ_HEX, 2'd0, 6'd1, 16'hFF09, 3'd2, 1'b0, 4'd0, 72'h0, 9'h0};
    dir_tab[23] = '{REQ_BAD6, 2'd1, 6'd1, 16'h0041, 3'd0, 1'b1, 4'd0, 72'h0, 9'h0};
    dir_tab[24] = '{REQ_BAD7, 2'd2, 6'd63, 16'hFFFF, 3'd7, 1'b1, 4'd0, 72'h0, 9'h0};

    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) begin
      r = dir_tab[i];
      send_request(r.kind, r.row, r.col, r.value, r.len);
      if (r.fixed) begin
        for (int b = 0; b < r.n_fix; b++) begin
          w.bus_byte = r.fix_byte[b];
          w.is_data  = r.fix_data[b];
          w.last     = (b == r.n_fix - 1);
          lcd_expect_q.push_back(w);
        end
      end else begin
        format_request(r.kind, r.row, r.col, r.value, r.len);
      end
    end

    drain_requests();

    sent_ok = 0;
    idx     = 0;
    while (sent_ok < RAND_REQS) begin
      quiet <= (idx >= 100 && idx < 180);
      if (idx == 220) drain_requests();

      pick = $urandom_range(99);
      if (pick < 4) k = (pick < 2) ? REQ_BAD6 : REQ_BAD7;
      else k = 3'($urandom_range(5));
      rw = 2'($urandom_range(3));
      if ($urandom_range(99) < 85) cl = 6'($urandom_range(40, 1));
      else cl = 6'($urandom_range(63, 0));
      pick = $urandom_range(99);
      if (pick < 8) val = 16'h0000;
      else if (pick < 16) val = 16'hFFFF;
      else if (pick < 22) val = 16'h8000;
      else if (pick < 28) val = 16'h7FFF;
      else val = 16'($urandom);
      len = 3'($urandom_range(7));

      send_request(k, rw, cl, val, len);
      format_request(k, rw, cl, val, len);
      if (k <= REQ_HEX) sent_ok++;
      idx++;
    end
    quiet     <= 1'b0;
    req_valid <= 1'b0;

    while (lcd_expect_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d init, %0d char, %0d udec, %0d sdec, %0d bin, %0d hex requests",
             kind_seen[REQ_INIT], kind_seen[REQ_CHAR], kind_seen[REQ_UDEC],
             kind_seen[REQ_SDEC], kind_seen[REQ_BIN], kind_seen[REQ_HEX]);
    $display("plus %0d ignored-type requests; %0d lcd bytes checked, %0d failures",
             kind_seen[REQ_BAD6] + kind_seen[REQ_BAD7], bytes_seen, fail_cnt);
    if (fail_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[char_lcd_write_formatter_top.f]
+incdir+rtl/core
rtl/core/clwf_pkg.sv
rtl/core/clwf_bcd.sv
rtl/core/clwf_emit.sv
rtl/core/char_lcd_write_formatter_top.sv
tb/sv/char_lcd_write_formatter_top_tb.sv
